// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held low
`define CAPI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("capi assertion failed");

// clocked assertion that also holds during reset
`define CAPI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("capi assertion failed");

`endif

// ===== src/capi_pkg.sv =====
// shared types, constants and tables of the arc point interpolator
// no dependencies
package capi_pkg;

    localparam int DEF_MAX_ARC_POINTS = 64;
    localparam int DEF_CORDIC_STAGES  = 24;

    localparam int CDW    = 37;   // cordic datapath width, signed
    localparam int MAGW   = 36;   // vector length width, unsigned
    localparam int DNW    = 37;   // divider numerator width
    localparam int PRODW  = 60;   // length times inverse gain
    localparam int NPW    = 7;    // point count width

    localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
    localparam logic [NPW-1:0] ARC_POINTS_RST = 7'd20;

    localparam logic MODE_ROT = 1'b0;
    localparam logic MODE_VEC = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_cordic_cmd;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/cnc_arc_point_interpolator_top.sv =====
// Arc point interpolator: a line beat gives its end point on the output the cycle after it
// is taken. An arc from a known position runs two atan2/length passes and three divider
// runs, then one cordic rotation per point, all on the one shared cordic unit and the
// bit-serial divider, plus any output stall. An arc from an unknown position gives no
// point and is done in the cycle it is taken. The input is ready only between segments, and
// not while a point waits on the output unless that point is taken in the same cycle.
// depends on capi_pkg and capi_cordic
module cnc_arc_point_interpolator_top
    import capi_pkg::*;
#(
    parameter int MAX_ARC_POINTS = DEF_MAX_ARC_POINTS,
    parameter int CORDIC_STAGES  = DEF_CORDIC_STAGES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [6:0]     i_cfg_data,   // arc_points
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [159:0]   i_s_tdata,    // end_x, end_y, end_z, center_i, center_j
    input  logic [1:0]     i_s_tuser,    // kind, direction
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [95:0]    o_m_tdata,    // point_x, point_y, point_z
    output logic           o_m_tlast
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VS   = 4'd1;
    localparam logic [3:0] S_VSW  = 4'd2;
    localparam logic [3:0] S_VSU  = 4'd3;
    localparam logic [3:0] S_VE   = 4'd4;
    localparam logic [3:0] S_VEW  = 4'd5;
    localparam logic [3:0] S_VEU  = 4'd6;
    localparam logic [3:0] S_SWP  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_PT   = 4'd9;
    localparam logic [3:0] S_PM   = 4'd10;
    localparam logic [3:0] S_PU   = 4'd11;
    localparam logic [3:0] S_PW   = 4'd12;
    localparam logic [3:0] S_PO   = 4'd13;

    localparam int DCW = $clog2(DNW + 1);

    logic [3:0]            r_state;
    logic [NPW-1:0]        r_ap;
    logic signed [31:0]    r_cx, r_cy, r_cz;
    logic                  r_known;
    logic signed [31:0]    r_ex, r_ey, r_ez, r_ci, r_cj;
    logic                  r_dir;
    logic [NPW-1:0]        r_n, r_k;
    logic [31:0]           r_as, r_ae, r_ang;
    logic [MAGW-1:0]       r_rs, r_re;
    logic [PRODW-1:0]      r_prod;
    logic signed [32:0]    r_ccx, r_ccy;
    logic signed [31:0]    r_pz;
    logic [1:0]            r_dsel;
    logic [DCW-1:0]        r_dcnt;
    logic [DNW-1:0]        r_dq;
    logic [NPW-1:0]        r_drem;
    logic [DNW-1:0]        r_qa  [3];
    logic [NPW-1:0]        r_qb  [3];
    logic                  r_sg  [3];
    logic [DNW-1:0]        r_aq  [3];
    logic [NPW-1:0]        r_ar  [3];
    logic                  r_ov;
    logic [95:0]           r_od;
    logic                  r_ol;

    t_cordic_cmd           cmd;
    logic signed [CDW-1:0] cx_in, cy_in, cx_o, cy_o;
    logic [31:0]           cz_in, cz_o;
    logic                  c_done;

    logic signed [33:0]    vex, vey;
    logic [NPW-1:0]        n_clamp;
    logic signed [37:0]    d_val [3];
    logic signed [33:0]    sweep;
    logic [31:0]           dang;
    logic [NPW:0]          dt;
    logic [MAGW-1:0]       uns;
    logic signed [DNW:0]   part [3];
    logic signed [37:0]    sum_x, sum_y;
    logic signed [MAGW+1:0] r_next;

    capi_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_x    (cx_in),
        .i_y    (cy_in),
        .i_z    (cz_in),
        .o_done (c_done),
        .o_x    (cx_o),
        .o_y    (cy_o),
        .o_z    (cz_o)
    );

    assign vex = 34'(r_ex) - 34'(r_cx) - 34'(r_ci);
    assign vey = 34'(r_ey) - 34'(r_cy) - 34'(r_cj);
    assign uns = MAGW'((r_prod + PRODW'(1 << 23)) >> 24);

    always_comb begin
        cmd   = '{start: 1'b0, mode: MODE_VEC};
        cx_in = -CDW'(r_ci);
        cy_in = -CDW'(r_cj);
        cz_in = r_ang;
        unique case (r_state)
            S_VS: begin
                cmd.start = !(r_ci == 0 && r_cj == 0);
            end
            S_VE: begin
                cmd.start = !(vex == 0 && vey == 0);
                cx_in     = CDW'(vex);
                cy_in     = CDW'(vey);
            end
            S_PU: begin
                cmd   = '{start: 1'b1, mode: MODE_ROT};
                cx_in = $signed({1'b0, uns});
                cy_in = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_ap == 0) begin
            n_clamp = NPW'(1);
        end else if (int'(r_ap) > MAX_ARC_POINTS) begin
            n_clamp = NPW'(MAX_ARC_POINTS);
        end else begin
            n_clamp = r_ap;
        end
    end

    always_comb begin
        if (r_dir) begin
            dang  = r_ae - r_as;
            sweep = (dang != 0) ? 34'($unsigned(dang)) : 34'sh1_0000_0000;
        end else begin
            dang  = r_as - r_ae;
            sweep = (dang != 0) ? -34'($unsigned(dang)) : -34'sh1_0000_0000;
        end
        d_val[0] = 38'(sweep);
        d_val[1] = 38'($signed({1'b0, r_re})) - 38'($signed({1'b0, r_rs}));
        d_val[2] = 38'(r_ez) - 38'(r_cz);
    end

    assign dt = {r_drem, r_dq[DNW-1]};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            part[j] = r_sg[j] ? -$signed({1'b0, r_aq[j]}) : $signed({1'b0, r_aq[j]});
        end
        r_next = $signed({2'b0, r_rs}) + (MAGW+2)'(part[1]);
        sum_x  = 38'(r_ccx) + 38'(cx_o);
        sum_y  = 38'(r_ccy) + 38'(cy_o);
    end

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -38'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ap    <= ARC_POINTS_RST;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_known <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_ap <= i_cfg_data;
            if (r_ov && i_m_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        r_ex  <= i_s_tdata[31:0];
                        r_ey  <= i_s_tdata[63:32];
                        r_ez  <= i_s_tdata[95:64];
                        r_ci  <= i_s_tdata[127:96];
                        r_cj  <= i_s_tdata[159:128];
                        r_dir <= i_s_tuser[1];
                        if (!i_s_tuser[0]) begin
                            r_ov <= 1'b1;
                            r_od <= i_s_tdata[95:0];
                            r_ol <= 1'b1;
                        end
                        if (!i_s_tuser[0] || !r_known) begin
                            r_cx    <= i_s_tdata[31:0];
                            r_cy    <= i_s_tdata[63:32];
                            r_cz    <= i_s_tdata[95:64];
                            r_known <= 1'b1;
                        end else begin
                            r_state <= S_VS;
                        end
                    end
                end
                S_VS: begin
                    r_n   <= n_clamp;
                    r_ccx <= 33'(r_cx) + 33'(r_ci);
                    r_ccy <= 33'(r_cy) + 33'(r_cj);
                    if (cmd.start) begin
                        r_state <= S_VSW;
                    end else begin
                        r_as    <= '0;
                        r_rs    <= '0;
                        r_state <= S_VE;
                    end
                end
                S_VSW: begin
                    if (c_done) begin
                        r_as    <= cz_o;
                        r_prod  <= PRODW'(cx_o[MAGW-1:0]) * PRODW'(INV_GAIN_Q24);
                        r_state <= S_VSU;
                    end
                end
                S_VSU: begin
                    r_rs    <= uns;
                    r_state <= S_VE;
                end
                S_VE: begin
                    if (cmd.start) begin
                        r_state <= S_VEW;
                    end else begin
                        r_ae    <= '0;
                        r_re    <= '0;
                        r_dsel  <= '0;
                        r_state <= S_SWP;
                    end
                end
                S_VEW: begin
                    if (c_done) begin
                        r_ae    <= cz_o;
                        r_prod  <= PRODW'(cx_o[MAGW-1:0]) * PRODW'(INV_GAIN_Q24);
                        r_state <= S_VEU;
                    end
                end
                S_VEU: begin
                    r_re    <= uns;
                    r_dsel  <= '0;
                    r_state <= S_SWP;
                end
                S_SWP: begin
                    r_sg[r_dsel] <= d_val[r_dsel][37];
                    r_dq    <= d_val[r_dsel][37] ? DNW'(-d_val[r_dsel]) : DNW'(d_val[r_dsel]);
                    r_drem  <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dt >= {1'b0, r_n}) begin
                        r_drem <= NPW'(dt - {1'b0, r_n});
                        r_dq   <= {r_dq[DNW-2:0], 1'b1};
                    end else begin
                        r_drem <= dt[NPW-1:0];
                        r_dq   <= {r_dq[DNW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(DNW - 1)) begin
                        if (dt >= {1'b0, r_n}) begin
                            r_qa[r_dsel] <= {r_dq[DNW-2:0], 1'b1};
                            r_qb[r_dsel] <= NPW'(dt - {1'b0, r_n});
                        end else begin
                            r_qa[r_dsel] <= {r_dq[DNW-2:0], 1'b0};
                            r_qb[r_dsel] <= dt[NPW-1:0];
                        end
                        if (r_dsel == 2'd2) begin
                            for (int j = 0; j < 3; j++) begin
                                r_aq[j] <= '0;
                                r_ar[j] <= '0;
                            end
                            r_k     <= '0;
                            r_state <= S_PT;
                        end else begin
                            r_dsel  <= r_dsel + 1'b1;
                            r_state <= S_SWP;
                        end
                    end
                end
                S_PT: begin
                    for (int j = 0; j < 3; j++) begin
                        if (({1'b0, r_ar[j]} + {1'b0, r_qb[j]}) >= {1'b0, r_n}) begin
                            r_ar[j] <= NPW'({1'b0, r_ar[j]} + {1'b0, r_qb[j]} - {1'b0, r_n});
                            r_aq[j] <= r_aq[j] + r_qa[j] + 1'b1;
                        end else begin
                            r_ar[j] <= r_ar[j] + r_qb[j];
                            r_aq[j] <= r_aq[j] + r_qa[j];
                        end
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= S_PM;
                end
                S_PM: begin
                    r_ang   <= r_as + part[0][31:0];
                    r_pz    <= r_cz + part[2][31:0];
                    r_prod  <= PRODW'(r_next[MAGW-1:0]) * PRODW'(INV_GAIN_Q24);
                    r_state <= S_PU;
                end
                S_PU: begin
                    r_state <= S_PW;
                end
                S_PW: begin
                    if (c_done) r_state <= S_PO;
                end
                S_PO: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_od <= {r_pz, sat32(sum_y), sat32(sum_x)};
                        r_ol <= (r_k == r_n);
                        if (r_k == r_n) begin
                            r_cx    <= r_ex;
                            r_cy    <= r_ey;
                            r_cz    <= r_ez;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE) && (!r_ov || i_m_tready);
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_od;
    assign o_m_tlast   = r_ol;

endmodule

// ===== src/capi_cordic.sv =====
// iterative cordic, vectoring and rotation, one micro-rotation per cycle
// depends on capi_pkg
module capi_cordic
    import capi_pkg::*;
#(
    parameter int STAGES = DEF_CORDIC_STAGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cordic_cmd           i_cmd,
    input  logic signed [CDW-1:0] i_x,
    input  logic signed [CDW-1:0] i_y,
    input  logic [31:0]           i_z,
    output logic                  o_done,
    output logic signed [CDW-1:0] o_x,
    output logic signed [CDW-1:0] o_y,
    output logic [31:0]           o_z
);

    localparam int NIT  = (STAGES > 32) ? 32 : STAGES;
    localparam int CNTW = $clog2(NIT + 1);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_mode;
    logic [CNTW-1:0]       r_cnt;
    logic signed [CDW-1:0] r_x, r_y;
    logic signed [33:0]    r_z;

    logic signed [CDW-1:0] dx, dy;
    logic [31:0]           at;
    logic                  go_pos;
    logic signed [33:0]    z_in;

    assign dx     = r_y >>> r_cnt;
    assign dy     = r_x >>> r_cnt;
    assign at     = atan_lut(5'(r_cnt));
    assign go_pos = (r_mode == MODE_VEC) ? !r_y[CDW-1] : !r_z[33];
    assign z_in   = {{2{i_z[31]}}, i_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNTW'(NIT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_cmd.mode;
            if (i_cmd.mode == MODE_VEC) begin
                if (i_x[CDW-1]) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= 34'sh0_8000_0000;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else begin
                r_y <= i_y;
                priority if (z_in > 34'sh0_4000_0000) begin
                    r_z <= z_in - 34'sh0_8000_0000;
                    r_x <= -i_x;
                end else if (z_in < -34'sh0_4000_0000) begin
                    r_z <= z_in + 34'sh0_8000_0000;
                    r_x <= -i_x;
                end else begin
                    r_z <= z_in;
                    r_x <= i_x;
                end
            end
        end else if (r_busy) begin
            if (r_mode == MODE_VEC) begin
                if (go_pos) begin
                    r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + $signed({2'b0, at});
                end else begin
                    r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - $signed({2'b0, at});
                end
            end else begin
                if (go_pos) begin
                    r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - $signed({2'b0, at});
                end else begin
                    r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + $signed({2'b0, at});
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z[31:0];

endmodule

// ===== src/capi_checker.sv =====
// port-level checks of the arc point interpolator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module capi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         i_s_tvalid,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [95:0]  o_m_tdata,
    input logic         o_m_tlast
);

    logic        in_beat;
    logic        out_wait;
    logic [96:0] out_word;

    assign in_beat  = i_s_tvalid && o_s_tready;
    assign out_wait = o_m_tvalid && !i_m_tready;
    assign out_word = {o_m_tlast, o_m_tdata};

    `CAPI_ASSERT(a_in_beat_frees_out, i_clk, i_rst_n, in_beat |-> !out_wait)
    `CAPI_ASSERT(a_out_hold, i_clk, i_rst_n, out_wait |=> (o_m_tvalid && $stable(out_word)))
    `CAPI_ASSERT(a_out_known, i_clk, i_rst_n, o_m_tvalid |-> !$isunknown(out_word))
    `CAPI_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind cnc_arc_point_interpolator_top capi_checker u_capi_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .i_s_tvalid(i_s_tvalid),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast)
);
